// ===== hw/rtl/jptq_pkg.sv =====
// Shared constants and types for the jump point table query block.
package jptq_pkg;

    // Default table size in cells.
    localparam int MAX_CELLS_DEF = 65536;

    // Labels per cell, one for each direction.
    localparam int NUM_DIRECTIONS = 8;
    localparam int DIR_W = $clog2(NUM_DIRECTIONS);

    // Label layout: the top bit marks a dead end.
    localparam int DEAD_BIT = 15;

    // Request operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Direction codes.
    localparam logic [2:0] DIR_N  = 3'd0;
    localparam logic [2:0] DIR_S  = 3'd1;
    localparam logic [2:0] DIR_E  = 3'd2;
    localparam logic [2:0] DIR_WE = 3'd3;
    localparam logic [2:0] DIR_NE = 3'd4;
    localparam logic [2:0] DIR_NW = 3'd5;
    localparam logic [2:0] DIR_SE = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CELLS  = 2'd2;

    // Divider request and response.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [15:0] remainder;
    } div_rsp_t;

endpackage

// ===== hw/rtl/jptq_div.sv =====
// Radix-2 restoring divider, 32-bit dividend by 16-bit nonzero divisor.
module jptq_div
    import jptq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] acc_reg;
    logic [31:0] q_reg;
    logic [15:0] d_reg;

    logic [16:0] shifted;
    logic        ge;
    logic [16:0] diff;
    logic [15:0] acc_next;
    logic [31:0] q_next;

    // One quotient bit per cycle.
    always_comb
    begin
        shifted  = {acc_reg, q_reg[31]};
        ge       = (shifted >= {1'b0, d_reg});
        diff     = shifted - {1'b0, d_reg};
        acc_next = ge ? diff[15:0] : shifted[15:0];
        q_next   = {q_reg[30:0], ge};
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= 16'd0;
            q_reg   <= req.dividend;
            d_reg   <= req.divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            q_reg   <= q_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = acc_reg;

endmodule

// ===== hw/rtl/jump_point_table_query_top.sv =====
// Jump point table query: label table, query sequencer and shared divider.
//
// A write request stores one label. A query runs under a small
// sequencer that shares one 32-step divider and one 16x16 multiplier, and the
// block takes no new request until the query has handed its result to the output
// register. An east or west query needs no division; a north or south query needs
// three divisions; a diagonal query needs two divisions for the coordinates when
// the goal lies less than the configured cell count ahead, then possibly a straight
// jump east, west, north or south. The divider yields one quotient bit per cycle;
// a stalled output register holds the sequencer in its last state.
module jump_point_table_query_top
    import jptq_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [15:0] cell_id,
    input  logic [2:0]  direction,
    input  logic [15:0] goal_cell,
    input  logic [15:0] label_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        node_valid,
    output logic [15:0] jump_node,
    output logic [14:0] diagonal_steps,
    output logic [15:0] straight_steps,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int CELL_W = $clog2(MAX_CELLS);
    localparam int DEPTH  = MAX_CELLS * NUM_DIRECTIONS;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LRD    = 5'd1;
    localparam logic [4:0] S_LWAIT  = 5'd2;
    localparam logic [4:0] S_C_GD   = 5'd3;
    localparam logic [4:0] S_C_D1S  = 5'd4;
    localparam logic [4:0] S_C_D1W  = 5'd5;
    localparam logic [4:0] S_C_D2S  = 5'd6;
    localparam logic [4:0] S_C_D2W  = 5'd7;
    localparam logic [4:0] S_C_D3S  = 5'd8;
    localparam logic [4:0] S_C_D3W  = 5'd9;
    localparam logic [4:0] S_C_FIN  = 5'd10;
    localparam logic [4:0] S_D_GS   = 5'd11;
    localparam logic [4:0] S_D_GW   = 5'd12;
    localparam logic [4:0] S_D_NS   = 5'd13;
    localparam logic [4:0] S_D_NW   = 5'd14;
    localparam logic [4:0] S_D_SEL  = 5'd15;
    localparam logic [4:0] S_D_MUL  = 5'd16;
    localparam logic [4:0] S_D_NODE = 5'd17;
    localparam logic [4:0] S_F_MUL  = 5'd18;
    localparam logic [4:0] S_F_OUT  = 5'd19;

    // Configuration registers.
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [16:0] cells_reg;

    // Sequencer state and query registers.
    logic [4:0]  state_reg, state_next;
    logic        sub_reg;
    logic [15:0] node0_reg;
    logic [15:0] goal_reg;
    logic [2:0]  dir_reg;
    logic [31:0] cur_node_reg;
    logic [2:0]  cur_dir_reg;
    logic [15:0] lab0_reg;
    logic [15:0] clab_reg;
    logic [31:0] gd_reg;
    logic [15:0] nmod_reg;
    logic [15:0] gmod_reg;
    logic [31:0] gq_reg;
    logic [15:0] gx_reg;
    logic [15:0] gy_reg;
    logic [15:0] nx_reg;
    logic [15:0] ny_reg;
    logic [15:0] k_reg;
    logic [31:0] mul_reg;
    logic        oob_reg;
    logic [15:0] mem_q_reg;

    // Output register.
    logic        out_valid_reg;
    logic        node_valid_reg;
    logic [15:0] jump_node_reg;
    logic [14:0] diag_reg;
    logic [15:0] straight_reg;

    // Label table.
    logic [15:0] label_mem [DEPTH];

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [15:0] w;
    logic        in_acc;
    logic        out_free;
    logic [15:0] lab;
    logic [14:0] n0;
    logic [14:0] n_c;
    logic        north;
    logic        east;
    logic [31:0] goal32;
    logic [31:0] node32;
    logic [31:0] ahead;
    logic [31:0] dy32;
    logic [31:0] dx32;
    logic        box_ok;
    logic        ns;
    logic        c_hit;
    logic        c_dead;
    logic        c_valid;
    logic [31:0] c_node;
    logic [31:0] c_straight;
    logic [31:0] fnode;
    logic [15:0] mul_a;
    logic        res_load;
    logic        res_valid;
    logic [15:0] res_node;
    logic [14:0] res_diag;
    logic [15:0] res_straight;
    logic        goto_sub;
    logic [2:0]  sub_dir;
    logic [15:0] sub_k;
    logic [31:0] write_cell;

    assign w         = (width_reg == 16'd0) ? 16'd1 : width_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign lab    = oob_reg ? 16'd0 : mem_q_reg;
    assign n0     = lab0_reg[14:0];
    assign n_c    = clab_reg[14:0];
    assign north  = (dir_reg == DIR_NE) || (dir_reg == DIR_NW);
    assign east   = (dir_reg == DIR_NE) || (dir_reg == DIR_SE);
    assign goal32 = {16'd0, goal_reg};
    assign node32 = {16'd0, node0_reg};
    assign write_cell = {16'd0, cell_id};

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            cells_reg  <= 17'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[15:0];
                CFG_HEIGHT: height_reg <= cfg_data[15:0];
                CFG_CELLS:  cells_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Label table write port.
    always_ff @(posedge clk)
    begin
        if (in_acc && (op == OP_WRITE) && (write_cell < 32'(MAX_CELLS)))
        begin
            label_mem[{write_cell[CELL_W-1:0], direction}] <= label_value;
        end
    end

    // Label table read port; cells past the table read as zero.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LRD)
        begin
            mem_q_reg <= label_mem[{cur_node_reg[CELL_W-1:0], cur_dir_reg}];
            oob_reg   <= (cur_node_reg >= 32'(MAX_CELLS));
        end
    end

    // Shared multiplier by the row stride. The cardinal states keep the
    // product of the cardinal step count until the jump is resolved.
    always_comb
    begin
        case (state_reg)
            S_C_GD, S_C_D1S, S_C_D1W, S_C_D2S, S_C_D2W, S_C_D3S, S_C_D3W, S_C_FIN:
                mul_a = {1'b0, n_c};
            S_D_MUL: mul_a = k_reg;
            default: mul_a = {1'b0, n0};
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= {16'd0, mul_a} * {16'd0, w};
    end

    jptq_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Divider requests.
    always_comb
    begin
        div_req.divisor = w;
        div_req.start   = 1'b0;
        div_req.dividend = cur_node_reg;
        case (state_reg)
            S_C_D1S:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = cur_node_reg;
            end
            S_C_D2S, S_D_GS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = goal32;
            end
            S_C_D3S:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = gd_reg;
            end
            S_D_NS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = node32;
            end
            default: ;
        endcase
    end

    // Diagonal geometry.
    always_comb
    begin
        ahead  = north ? (node32 - goal32) : (goal32 - node32);
        dy32   = north ? ({16'd0, ny_reg} - {16'd0, gy_reg})
                       : ({16'd0, gy_reg} - {16'd0, ny_reg});
        dx32   = east  ? ({16'd0, gx_reg} - {16'd0, nx_reg})
                       : ({16'd0, nx_reg} - {16'd0, gx_reg});
        box_ok = (dx32 < {16'd0, w}) && (dy32 < {16'd0, height_reg});
        goto_sub = 1'b0;
        sub_dir  = DIR_N;
        sub_k    = 16'd0;
        if (box_ok)
        begin
            if ((dy32 < dx32) && (dy32 <= {17'd0, n0}))
            begin
                goto_sub = 1'b1;
                sub_k    = dy32[15:0];
                sub_dir  = east ? DIR_E : DIR_WE;
            end
            else if (dx32 <= {17'd0, n0})
            begin
                goto_sub = 1'b1;
                sub_k    = dx32[15:0];
                sub_dir  = north ? DIR_N : DIR_S;
            end
        end
        fnode = node32 + (north ? (32'd0 - mul_reg) : mul_reg)
                       + (east ? {17'd0, n0} : (32'd0 - {17'd0, n0}));
    end

    // Cardinal jump outcome.
    always_comb
    begin
        ns     = (cur_dir_reg == DIR_N) || (cur_dir_reg == DIR_S);
        c_dead = clab_reg[DEAD_BIT];
        if (ns)
        begin
            c_hit      = (mul_reg >= gd_reg) && (nmod_reg == gmod_reg);
            c_straight = c_hit ? gq_reg : {17'd0, n_c};
            c_node     = (cur_dir_reg == DIR_N) ? (cur_node_reg - mul_reg)
                                                : (cur_node_reg + mul_reg);
        end
        else
        begin
            c_hit      = ({17'd0, n_c} >= gd_reg);
            c_straight = c_hit ? gd_reg : {17'd0, n_c};
            c_node     = (cur_dir_reg == DIR_E) ? (cur_node_reg + {17'd0, n_c})
                                                : (cur_node_reg - {17'd0, n_c});
        end
        if (c_hit)
        begin
            c_node = goal32;
        end
        c_valid = c_hit || !c_dead;
        if (!c_valid)
        begin
            c_node     = 32'd0;
            c_straight = 32'd0;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        res_load     = 1'b0;
        res_valid    = 1'b0;
        res_node     = 16'd0;
        res_diag     = 15'd0;
        res_straight = 16'd0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (op == OP_QUERY))
                begin
                    state_next = S_LRD;
                end
            end
            S_LRD:
            begin
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (!sub_reg && (dir_reg >= DIR_NE))
                begin
                    state_next = (ahead < {15'd0, cells_reg}) ? S_D_GS : S_F_MUL;
                end
                else
                begin
                    state_next = S_C_GD;
                end
            end
            S_C_GD:
            begin
                state_next = ((cur_dir_reg == DIR_N) || (cur_dir_reg == DIR_S))
                             ? S_C_D1S : S_C_FIN;
            end
            S_C_D1S: state_next = S_C_D1W;
            S_C_D1W:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_C_D2S;
                end
            end
            S_C_D2S: state_next = S_C_D2W;
            S_C_D2W:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_C_D3S;
                end
            end
            S_C_D3S: state_next = S_C_D3W;
            S_C_D3W:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_C_FIN;
                end
            end
            S_C_FIN:
            begin
                if (sub_reg && !(c_valid && (c_node == goal32)))
                begin
                    state_next = S_F_MUL;
                end
                else if (out_free)
                begin
                    res_load     = 1'b1;
                    res_valid    = c_valid;
                    res_node     = c_node[15:0];
                    res_diag     = sub_reg ? k_reg[14:0] : 15'd0;
                    res_straight = c_straight[15:0];
                    state_next   = S_IDLE;
                end
            end
            S_D_GS: state_next = S_D_GW;
            S_D_GW:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_D_NS;
                end
            end
            S_D_NS: state_next = S_D_NW;
            S_D_NW:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_D_SEL;
                end
            end
            S_D_SEL:
            begin
                state_next = goto_sub ? S_D_MUL : S_F_MUL;
            end
            S_D_MUL:  state_next = S_D_NODE;
            S_D_NODE: state_next = S_LRD;
            S_F_MUL:  state_next = S_F_OUT;
            S_F_OUT:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (!lab0_reg[DEAD_BIT])
                    begin
                        res_valid = 1'b1;
                        res_node  = fnode[15:0];
                        res_diag  = n0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sub_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                sub_reg <= 1'b0;
            end
            else if (state_reg == S_D_NODE)
            begin
                sub_reg <= 1'b1;
            end
        end
    end

    // Query datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    node0_reg    <= cell_id;
                    goal_reg     <= goal_cell;
                    dir_reg      <= direction;
                    cur_node_reg <= write_cell;
                    cur_dir_reg  <= direction;
                end
            end
            S_LWAIT:
            begin
                clab_reg <= lab;
                if (!sub_reg)
                begin
                    lab0_reg <= lab;
                end
            end
            S_C_GD:
            begin
                if ((cur_dir_reg == DIR_N) || (cur_dir_reg == DIR_WE))
                begin
                    gd_reg <= cur_node_reg - goal32;
                end
                else
                begin
                    gd_reg <= goal32 - cur_node_reg;
                end
            end
            S_C_D1W:
            begin
                nmod_reg <= div_rsp.remainder;
            end
            S_C_D2W:
            begin
                gmod_reg <= div_rsp.remainder;
            end
            S_C_D3W:
            begin
                gq_reg <= div_rsp.quotient;
            end
            S_D_GW:
            begin
                gx_reg <= div_rsp.remainder;
                gy_reg <= div_rsp.quotient[15:0];
            end
            S_D_NW:
            begin
                nx_reg <= div_rsp.remainder;
                ny_reg <= div_rsp.quotient[15:0];
            end
            S_D_SEL:
            begin
                k_reg       <= sub_k;
                cur_dir_reg <= sub_dir;
            end
            S_D_NODE:
            begin
                cur_node_reg <= node32 + (north ? (32'd0 - mul_reg) : mul_reg)
                                       + (east ? {16'd0, k_reg}
                                               : (32'd0 - {16'd0, k_reg}));
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            node_valid_reg <= res_valid;
            jump_node_reg  <= res_node;
            diag_reg       <= res_diag;
            straight_reg   <= res_straight;
        end
    end

    assign out_valid      = out_valid_reg;
    assign node_valid     = node_valid_reg;
    assign jump_node      = jump_node_reg;
    assign diagonal_steps = diag_reg;
    assign straight_steps = straight_reg;

endmodule

// ===== dv/testbench.sv =====
// Jump point table query testbench: directed and random requests, checked by table or predictor.
`timescale 1ns / 1ps

module testbench;
    import jptq_pkg::*;

    localparam int unsigned TABLE_CELLS = 65536;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 250;

    // One result as the block reports it.
    typedef struct packed {
        logic        nv;
        logic [15:0] node;
        logic [14:0] dg;
        logic [15:0] st;
    } result_t;

    // Full-width jump outcome used inside the predictor.
    typedef struct {
        bit          nv;
        bit [31:0]   node;
        bit [31:0]   dg;
        bit [31:0]   st;
    } jump_t;

    // One row of the directed table.
    typedef struct packed {
        logic        op;
        logic [15:0] cell_no;
        logic [2:0]  dir;
        logic [15:0] goal;
        logic [15:0] label;
        logic        typed;
        result_t     res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [15:0] cell_id;
    logic [2:0]  direction;
    logic [15:0] goal_cell;
    logic [15:0] label_value;
    logic        out_valid;
    logic        out_stall;
    logic        node_valid;
    logic [15:0] jump_node;
    logic [14:0] diagonal_steps;
    logic [15:0] straight_steps;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    jump_point_table_query_top DUT (.*);

    // Predictor state: label table, grid registers and unwritten reads.
    logic [15:0]  label_mem [int unsigned];
    int unsigned  missing [$];
    bit   [31:0]  grid_w;
    bit   [31:0]  grid_h;
    bit   [31:0]  grid_n;

    result_t      expected_q [$];
    int           mismatches;
    int           burst_left;
    int           max_gap;
    int           stall_mode;
    int           idle_cycles;

    localparam row_t DIRECTED [0:13] = '{
        '{OP_WRITE, 16'd0,     DIR_N,  16'd0,     16'h8000, 1'b0, '0},
        '{OP_QUERY, 16'd0,     DIR_N,  16'd5,     16'h0000, 1'b1, '{1'b0, 16'd0, 15'd0, 16'd0}},
        '{OP_QUERY, 16'd0,     DIR_N,  16'd0,     16'h0000, 1'b1, '{1'b1, 16'd0, 15'd0, 16'd0}},
        '{OP_WRITE, 16'd65535, DIR_E,  16'd0,     16'h7FFF, 1'b0, '0},
        '{OP_QUERY, 16'd65535, DIR_E,  16'd0,     16'h0000, 1'b1,
          '{1'b1, 16'd32766, 15'd0, 16'd32767}},
        '{OP_WRITE, 16'd0,     DIR_NE, 16'd0,     16'h0000, 1'b0, '0},
        '{OP_QUERY, 16'd0,     DIR_NE, 16'd0,     16'h0000, 1'b1, '{1'b1, 16'd0, 15'd0, 16'd0}},
        '{OP_WRITE, 16'd100,   DIR_S,  16'd0,     16'h0003, 1'b0, '0},
        '{OP_QUERY, 16'd100,   DIR_S,  16'd102,   16'h0000, 1'b1,
          '{1'b1, 16'd102, 15'd0, 16'd2}},
        '{OP_WRITE, 16'd100,   DIR_WE, 16'd0,     16'h0005, 1'b0, '0},
        '{OP_QUERY, 16'd100,   DIR_WE, 16'd200,   16'h0000, 1'b1,
          '{1'b1, 16'd95, 15'd0, 16'd5}},
        '{OP_WRITE, 16'd7,     DIR_NW, 16'd0,     16'h8002, 1'b0, '0},
        '{OP_QUERY, 16'd7,     DIR_NW, 16'd65535, 16'h0000, 1'b1, '{1'b0, 16'd0, 15'd0, 16'd0}},
        '{OP_QUERY, 16'd7,     DIR_SE, 16'd40,    16'h0000, 1'b0, '0}
    };

    // Label lookup; cells past the table read as zero.
    function automatic bit [15:0] read_label(bit [31:0] at_cell, bit [2:0] slot);
        int unsigned idx;
        if (at_cell >= TABLE_CELLS) return 16'd0;
        idx = at_cell * 8 + slot;
        if (!label_mem.exists(idx))
        begin
            missing.push_back(idx);
            return 16'd0;
        end
        return label_mem[idx];
    endfunction

    function automatic bit [31:0] row_stride();
        return (grid_w == 0) ? 32'd1 : grid_w;
    endfunction

    // Dead-end labels clear the whole result.
    function automatic jump_t label_result(bit [15:0] label, bit [31:0] node,
                                           bit [31:0] dg, bit [31:0] st);
        jump_t r;
        if (label[DEAD_BIT])
            r = '{1'b0, 32'd0, 32'd0, 32'd0};
        else
            r = '{1'b1, node, dg, st};
        return r;
    endfunction

    // Straight jump along a row or a column.
    function automatic jump_t straight_jump(bit [2:0] dir, bit [31:0] node, bit [31:0] goal);
        bit [31:0] w;
        bit [15:0] label;
        bit [31:0] n;
        bit [31:0] delta;
        bit [31:0] gd;
        w = row_stride();
        label = read_label(node, dir);
        n = {17'd0, label[14:0]};
        if (dir == DIR_N || dir == DIR_S)
        begin
            delta = n * w;
            gd = (dir == DIR_N) ? node - goal : goal - node;
            if (delta >= gd && (node % w) == (goal % w))
                return '{1'b1, goal, 32'd0, gd / w};
            return label_result(label, (dir == DIR_N) ? node - delta : node + delta, 32'd0, n);
        end
        gd = (dir == DIR_E) ? goal - node : node - goal;
        if (n >= gd)
            return '{1'b1, goal, 32'd0, gd};
        return label_result(label, (dir == DIR_E) ? node + n : node - n, 32'd0, n);
    endfunction

    // Diagonal jump with the goal test inside the grid box.
    function automatic jump_t diagonal_jump(bit [2:0] dir, bit [31:0] node, bit [31:0] goal);
        bit [31:0] w;
        bit        north;
        bit        east;
        bit [15:0] label;
        bit [31:0] n;
        bit [31:0] step;
        bit [31:0] ahead;
        bit [31:0] dx;
        bit [31:0] dy;
        bit [31:0] k;
        bit [2:0]  cdir;
        bit        attempt;
        jump_t     c;
        w = row_stride();
        north = (dir == DIR_NE || dir == DIR_NW);
        east = (dir == DIR_NE || dir == DIR_SE);
        label = read_label(node, dir);
        n = {17'd0, label[14:0]};
        step = (north ? 32'd0 - w : w) + (east ? 32'd1 : 32'hFFFF_FFFF);
        ahead = north ? node - goal : goal - node;
        attempt = 1'b0;
        k = 0;
        cdir = DIR_N;
        if (ahead < grid_n)
        begin
            dy = north ? (node / w) - (goal / w) : (goal / w) - (node / w);
            dx = east ? (goal % w) - (node % w) : (node % w) - (goal % w);
            if (dx < w && dy < grid_h)
            begin
                if (dy < dx && dy <= n)
                begin
                    k = dy;
                    cdir = east ? DIR_E : DIR_WE;
                    attempt = 1'b1;
                end
                else if (dx <= n)
                begin
                    k = dx;
                    cdir = north ? DIR_N : DIR_S;
                    attempt = 1'b1;
                end
            end
        end
        if (attempt)
        begin
            c = straight_jump(cdir, node + step * k, goal);
            if (c.nv && c.node == goal)
                return '{1'b1, goal, k, c.st};
        end
        return label_result(label, node + step * n, n, 32'd0);
    endfunction

    function automatic result_t predict_query(bit [15:0] start, bit [2:0] dir, bit [15:0] goal);
        jump_t r;
        if (dir < DIR_NE)
            r = straight_jump(dir, {16'd0, start}, {16'd0, goal});
        else
            r = diagonal_jump(dir, {16'd0, start}, {16'd0, goal});
        return '{r.nv, r.node[15:0], r.dg[14:0], r.st[15:0]};
    endfunction

    function automatic bit [15:0] random_label();
        bit [15:0] steps;
        case ($urandom_range(0, 5))
            0: steps = 16'h7FFF;
            1: steps = 16'($urandom_range(0, 32767));
            default: steps = 16'($urandom_range(0, 12));
        endcase
        steps[15] = ($urandom_range(0, 4) == 0);
        return steps;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hand one request to the block, with idle gaps between bursts.
    task automatic send_request(bit o, bit [15:0] c, bit [2:0] d, bit [15:0] g,
                                bit [15:0] l, bit typed, result_t res);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= o;
        cell_id <= c;
        direction <= d;
        goal_cell <= g;
        label_value <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (o == OP_WRITE)
            label_mem[{16'd0, c} * 8 + d] = l;
        else
            expected_q.push_back(typed ? res : predict_query(c, d, g));
    endtask

    // Queries should not read an unwritten label: write the missing ones first, for up to four rounds.
    task automatic send_query(bit [15:0] c, bit [2:0] d, bit [15:0] g, bit typed, result_t res);
        result_t scratch;
        int unsigned idx;
        repeat (4)
        begin
            missing.delete();
            scratch = predict_query(c, d, g);
            if (missing.size() == 0) break;
            idx = missing[0];
            send_request(OP_WRITE, 16'(idx >> 3), 3'(idx), 16'd0, random_label(), 1'b0, '0);
        end
        send_request(OP_QUERY, c, d, g, 16'd0, typed, res);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [16:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  grid_w = {16'd0, data[15:0]};
            CFG_HEIGHT: grid_h = {16'd0, data[15:0]};
            default:    grid_n = {15'd0, data};
        endcase
    endtask

    // Reprogram the grid once the block has gone quiet.
    task automatic set_grid(bit [15:0] w, bit [15:0] h, bit [16:0] n);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_register(CFG_WIDTH, {1'b0, w});
        write_register(CFG_HEIGHT, {1'b0, h});
        write_register(CFG_CELLS, n);
    endtask

    // Random queries, mostly with goals placed on the jump path.
    task automatic random_phase(int count, bit pause_midway);
        bit [15:0] c;
        bit [2:0]  d;
        bit [15:0] g;
        bit [31:0] w;
        bit [31:0] lim;
        bit [31:0] span;
        bit [31:0] side;
        bit [15:0] l;
        w = row_stride();
        lim = (grid_n == 0 || grid_n > TABLE_CELLS) ? TABLE_CELLS : grid_n;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                drain_results();
            c = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, lim - 1));
            d = 3'($urandom_range(0, 7));
            span = $urandom_range(0, 12);
            side = $urandom_range(0, 12);
            case (d)
                DIR_N:   g = 16'(c - span * w);
                DIR_S:   g = 16'(c + span * w);
                DIR_E:   g = 16'(c + span);
                DIR_WE:  g = 16'(c - span);
                DIR_NE:  g = 16'(c - span * w + side);
                DIR_NW:  g = 16'(c - span * w - side);
                DIR_SE:  g = 16'(c + span * w + side);
                default: g = 16'(c + span * w - side);
            endcase
            if ($urandom_range(0, 4) == 0)
                g = 16'($urandom);
            if ($urandom_range(0, 9) < 7)
            begin
                l = random_label();
                if ($urandom_range(0, 2) == 0)
                    l[14:0] = 15'($urandom_range(0, 1) ? span : side);
                send_request(OP_WRITE, c, d, 16'($urandom), l, 1'b0, '0);
            end
            if ($urandom_range(0, 9) == 0)
                send_request(OP_WRITE, 16'($urandom), 3'($urandom), 16'($urandom),
                             16'($urandom), 1'b0, '0);
            send_query(c, d, g, 1'b0, '0);
        end
    endtask

    // Receiver: stall pattern and result check.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                default: out_stall <= ($urandom_range(0, 15) < 12);
            endcase
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: node_valid=%0d jump_node=%0d",
                                 node_valid, jump_node);
                end
                else if ({node_valid, jump_node, diagonal_steps, straight_steps}
                         !== expected_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected v=%0d node=%0d diag=%0d str=%0d, got v=%0d node=%0d diag=%0d str=%0d",
                                 expected_q[0].nv, expected_q[0].node, expected_q[0].dg,
                                 expected_q[0].st, node_valid, jump_node,
                                 diagonal_steps, straight_steps);
                    void'(expected_q.pop_front());
                end
                else
                    void'(expected_q.pop_front());
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_WRITE;
        cell_id = '0;
        direction = '0;
        goal_cell = '0;
        label_value = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        grid_w = 1;
        grid_h = 1;
        grid_n = 1;
        mismatches = 0;
        burst_left = 0;
        max_gap = 0;
        stall_mode = 0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset grid.
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].op == OP_WRITE)
                send_request(OP_WRITE, DIRECTED[i].cell_no, DIRECTED[i].dir, DIRECTED[i].goal,
                             DIRECTED[i].label, 1'b0, '0);
            else
                send_query(DIRECTED[i].cell_no, DIRECTED[i].dir, DIRECTED[i].goal,
                           DIRECTED[i].typed, DIRECTED[i].res);
        end

        // Random phases over several grid shapes, extremes among them.
        max_gap = 6;
        stall_mode = 1;
        set_grid(16'd8, 16'd8, 17'd64);
        random_phase(150, 1'b1);
        max_gap = 0;
        stall_mode = 0;
        set_grid(16'd16, 16'd4, 17'd64);
        random_phase(120, 1'b0);
        max_gap = 10;
        stall_mode = 2;
        set_grid(16'd0, 16'd0, 17'd0);
        random_phase(80, 1'b0);
        max_gap = 4;
        stall_mode = 1;
        set_grid(16'd65535, 16'd65535, 17'd65536);
        random_phase(150, 1'b0);
        set_grid(16'd256, 16'd256, 17'd65536);
        random_phase(150, 1'b0);
        max_gap = 3;
        stall_mode = 2;
        set_grid(16'd1, 16'd65535, 17'd65535);
        random_phase(100, 1'b0);
        stall_mode = 1;
        set_grid(16'd5, 16'd13, 17'd65);
        random_phase(150, 1'b0);
        set_grid(16'($urandom_range(1, 300)), 16'($urandom_range(1, 200)),
                 17'($urandom_range(1, 65536)));
        random_phase(150, 1'b0);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
